/* src/tman_pkg.sv */
package tman_pkg;

   // Fixed field widths
   localparam int CH_BITS     = 3;
   localparam int LEVEL_BITS  = 7;
   localparam int COUNT_BITS  = 7;
   localparam int SHIFT_BITS  = 3;
   localparam int CSR_BITS    = 8;

   // Top and bottom of the normalized scale, the largest usable window shift and its reset value
   localparam logic [LEVEL_BITS-1:0] LEVEL_TOP = 7'd99;
   localparam logic [LEVEL_BITS-1:0] LEVEL_BOT = 7'd0;
   localparam logic [SHIFT_BITS-1:0] MAX_SHIFT = 3'd6;
   localparam logic [SHIFT_BITS-1:0] SHIFT_RST = 3'd2;

   // Sequencer states
   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_ACCUM = 6'b000010,
      S_MEAN  = 6'b000100,
      S_LIMIT = 6'b001000,
      S_DIV   = 6'b010000,
      S_EMIT  = 6'b100000
   } tman_state_type;

endpackage

/* src/tman_ram.sv */
module tman_ram #(
   parameter int                WIDTH   = 8,
   parameter int                DEPTH   = 6,
   parameter int                ADDR_W  = 3,
   parameter logic [WIDTH-1:0]  RST_VAL = '0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;
   logic [DEPTH-1:0] vld_ff;
   logic             rd_vld_ff;

   // Storage array with registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   // Track written entries; an unwritten entry reads as its reset value
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : RST_VAL;

endmodule

/* src/tman_div.sv */
module tman_div import tman_pkg::*; #(
   parameter int DEN_BITS = 10
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [DEN_BITS+LEVEL_BITS-1:0] num,
   input  logic [DEN_BITS-1:0]          den,
   output logic                         done,
   output logic [LEVEL_BITS-1:0]        quot
);

   localparam int CNT_BITS = $clog2(LEVEL_BITS + 1);

   logic                  busy_ff;
   logic                  done_ff;
   logic [CNT_BITS-1:0]   cnt_ff;
   logic [DEN_BITS-1:0]   rem_ff;
   logic [DEN_BITS-1:0]   den_ff;
   logic [LEVEL_BITS-1:0] low_ff;
   logic [LEVEL_BITS-1:0] quot_ff;

   logic [DEN_BITS:0]     trial;
   logic                  fits;
   logic [DEN_BITS:0]     diff;
   logic [DEN_BITS-1:0]   rem_in;

   // One quotient bit per cycle: bring down a bit, try the subtract
   assign trial  = {rem_ff, low_ff[LEVEL_BITS-1]};
   assign diff   = trial - {1'b0, den_ff};
   assign fits   = (trial >= {1'b0, den_ff});
   assign rem_in = fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];

   // Step control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_BITS'(LEVEL_BITS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_BITS'(1);
            if (cnt_ff == CNT_BITS'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Remainder and quotient; the high part of num is known to be below den
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= num[DEN_BITS+LEVEL_BITS-1:LEVEL_BITS];
         low_ff  <= num[LEVEL_BITS-1:0];
         den_ff  <= den;
         quot_ff <= '0;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         low_ff  <= {low_ff[LEVEL_BITS-2:0], 1'b0};
         quot_ff <= {quot_ff[LEVEL_BITS-2:0], fits};
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

/* src/trimmed_mean_auto_range_normalizer.sv */
// Per-channel trimmed-mean filter with self-learning range normalization. Each
// req transaction carries a channel and a sample; channels at or above CHANNELS
// are dropped. A channel's window closes after 2^window_shift + 2 samples
// (shift capped at six); the peak and trough are removed, the rest is averaged
// and mapped to 0..99 against per-channel limits that widen as new extremes
// appear, and one rsp transaction is sent. A sample that does not close a
// window is accepted and its entry is read, updated and written back. A
// closing sample goes on through S_MEAN and S_LIMIT to S_EMIT, via S_DIV,
// where the 7-step divider forms the level, when the mean sets no new limit.
// A finished result waits in the rsp register while the next sample is taken.
// Memories need no clearing pass after reset. The user must write window_shift
// on the csr port only while no sample is in flight; this is not enforced.
module trimmed_mean_auto_range_normalizer import tman_pkg::*; #(
   parameter int CHANNELS    = 6,
   parameter int SAMPLE_BITS = 10
) (
   input  logic clock,
   input  logic reset,

   // csr_wdata: [2:0] window_shift, upper bits ignored
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CSR_BITS-1:0] csr_wdata,

   // req_tdata: channel, sample, zero fill
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [((CH_BITS+SAMPLE_BITS+7)/8)*8-1:0] req_tdata,

   // rsp_tdata: out_channel, level, filtered, zero fill
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [((CH_BITS+LEVEL_BITS+SAMPLE_BITS+7)/8)*8-1:0] rsp_tdata
);

   localparam int IDX_BITS  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CHW_BITS  = CH_BITS + IDX_BITS;
   localparam int SUM_BITS  = SAMPLE_BITS + COUNT_BITS;
   localparam int NUM_BITS  = SAMPLE_BITS + LEVEL_BITS;
   localparam int WIN_BITS  = COUNT_BITS + 2 * SAMPLE_BITS + SUM_BITS;
   localparam int LIM_BITS  = 2 * SAMPLE_BITS;
   localparam int RSP_BITS  = CH_BITS + LEVEL_BITS + SAMPLE_BITS;
   localparam int RSP_TBITS = ((RSP_BITS + 7) / 8) * 8;
   localparam logic [SAMPLE_BITS-1:0] SMAX = {SAMPLE_BITS{1'b1}};
   // window word: {count, trough, peak, sum}; limit word: {lower, upper}
   localparam logic [WIN_BITS-1:0] WIN_RST =
      {{COUNT_BITS{1'b0}}, SMAX, {SAMPLE_BITS{1'b0}}, {SUM_BITS{1'b0}}};
   localparam logic [LIM_BITS-1:0] LIM_RST = {SMAX, {SAMPLE_BITS{1'b0}}};

   tman_state_type state_ff, state_in;

   logic [SHIFT_BITS-1:0]  shift_ff;
   logic [IDX_BITS-1:0]    idx_ff;
   logic [CH_BITS-1:0]     chan_ff;
   logic [SAMPLE_BITS-1:0] sample_ff;
   logic [SUM_BITS-1:0]    sum_ff;
   logic [SAMPLE_BITS-1:0] peak_ff;
   logic [SAMPLE_BITS-1:0] trough_ff;
   logic [SAMPLE_BITS-1:0] mean_ff;
   logic [LEVEL_BITS-1:0]  level_ff, level_in;
   logic                   rsp_valid_ff;
   logic [CH_BITS-1:0]     rsp_chan_ff;
   logic [LEVEL_BITS-1:0]  rsp_level_ff;
   logic [SAMPLE_BITS-1:0] rsp_mean_ff;

   logic [CH_BITS-1:0]     req_channel;
   logic [SAMPLE_BITS-1:0] req_sample;
   logic [CHW_BITS-1:0]    chan_wide;
   logic [IDX_BITS-1:0]    req_idx;
   logic                   req_fire;
   logic                   chan_ok;

   logic                   win_wr;
   logic [WIN_BITS-1:0]    win_rd, win_wdata;
   logic                   lim_wr;
   logic [LIM_BITS-1:0]    lim_rd, lim_wdata;

   logic [COUNT_BITS-1:0]  cnt_old, cnt_new, win_len;
   logic [SUM_BITS-1:0]    sum_old, sum_new;
   logic [SAMPLE_BITS-1:0] peak_old, peak_new, trough_old, trough_new;
   logic [SHIFT_BITS-1:0]  sh_eff;
   logic                   win_done;

   logic [SUM_BITS-1:0]    trimmed, shifted;
   logic [SAMPLE_BITS-1:0] mean_in;
   logic [SAMPLE_BITS-1:0] lim_hi, lim_lo;
   logic [SAMPLE_BITS-1:0] span, offset;
   logic [NUM_BITS-1:0]    div_num;
   logic                   div_start, div_done;
   logic [LEVEL_BITS-1:0]  div_quot;
   logic                   emit_ok;

   // Unpack the request
   assign req_channel = req_tdata[CH_BITS-1:0];
   assign req_sample  = req_tdata[CH_BITS+SAMPLE_BITS-1:CH_BITS];
   assign chan_wide   = CHW_BITS'(req_channel);
   assign req_idx     = chan_wide[IDX_BITS-1:0];
   assign chan_ok     = (32'(req_channel) < CHANNELS);
   assign req_tready  = (state_ff == S_IDLE);
   assign req_fire    = req_tvalid && req_tready;
   assign csr_ready   = 1'b1;

   // Window and limit memories, one entry per channel
   tman_ram #(
      .WIDTH   (WIN_BITS),
      .DEPTH   (CHANNELS),
      .ADDR_W  (IDX_BITS),
      .RST_VAL (WIN_RST)
   ) u_win_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_fire && chan_ok),
      .rd_addr (req_idx),
      .rd_data (win_rd),
      .wr_en   (win_wr),
      .wr_addr (idx_ff),
      .wr_data (win_wdata)
   );

   tman_ram #(
      .WIDTH   (LIM_BITS),
      .DEPTH   (CHANNELS),
      .ADDR_W  (IDX_BITS),
      .RST_VAL (LIM_RST)
   ) u_lim_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_fire && chan_ok),
      .rd_addr (req_idx),
      .rd_data (lim_rd),
      .wr_en   (lim_wr),
      .wr_addr (idx_ff),
      .wr_data (lim_wdata)
   );

   // Accumulate the sample into the window entry
   assign sum_old    = win_rd[SUM_BITS-1:0];
   assign peak_old   = win_rd[SUM_BITS+SAMPLE_BITS-1:SUM_BITS];
   assign trough_old = win_rd[SUM_BITS+2*SAMPLE_BITS-1:SUM_BITS+SAMPLE_BITS];
   assign cnt_old    = win_rd[WIN_BITS-1:SUM_BITS+2*SAMPLE_BITS];
   assign sum_new    = sum_old + SUM_BITS'(sample_ff);
   assign peak_new   = (sample_ff > peak_old) ? sample_ff : peak_old;
   assign trough_new = (sample_ff < trough_old) ? sample_ff : trough_old;
   assign cnt_new    = cnt_old + COUNT_BITS'(1);
   assign sh_eff     = (shift_ff > MAX_SHIFT) ? MAX_SHIFT : shift_ff;
   assign win_len    = (COUNT_BITS'(1) << sh_eff) + COUNT_BITS'(2);
   assign win_done   = (cnt_new >= win_len);
   assign win_wr     = (state_ff == S_ACCUM);
   assign win_wdata  = win_done ? WIN_RST : {cnt_new, trough_new, peak_new, sum_new};

   // Drop peak and trough, average, saturate
   assign trimmed = sum_ff - SUM_BITS'(peak_ff) - SUM_BITS'(trough_ff);
   assign shifted = trimmed >> sh_eff;
   assign mean_in = (shifted > SUM_BITS'(SMAX)) ? SMAX : shifted[SAMPLE_BITS-1:0];

   // Compare against learned limits
   assign lim_hi  = lim_rd[SAMPLE_BITS-1:0];
   assign lim_lo  = lim_rd[LIM_BITS-1:SAMPLE_BITS];
   assign span    = lim_hi - lim_lo;
   assign offset  = mean_ff - lim_lo;
   assign div_num = NUM_BITS'(offset) * NUM_BITS'(LEVEL_TOP);

   always_comb begin
      lim_wr    = 1'b0;
      lim_wdata = lim_rd;
      div_start = 1'b0;
      level_in  = level_ff;
      if (state_ff == S_LIMIT) begin
         if (mean_ff >= lim_hi) begin
            lim_wr    = 1'b1;
            lim_wdata = {lim_lo, mean_ff};
            level_in  = LEVEL_TOP;
         end else if (mean_ff <= lim_lo) begin
            lim_wr    = 1'b1;
            lim_wdata = {mean_ff, lim_hi};
            level_in  = LEVEL_BOT;
         end else begin
            div_start = 1'b1;
         end
      end else if (state_ff == S_DIV && div_done) begin
         level_in = div_quot;
      end
   end

   tman_div #(
      .DEN_BITS (SAMPLE_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (span),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Output register frees when empty or taken
   assign emit_ok = !rsp_valid_ff || rsp_tready;

   // Sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire && chan_ok) begin
               state_in = S_ACCUM;
            end
         end
         S_ACCUM: begin
            state_in = win_done ? S_MEAN : S_IDLE;
         end
         S_MEAN: begin
            state_in = S_LIMIT;
         end
         S_LIMIT: begin
            state_in = div_start ? S_DIV : S_EMIT;
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (emit_ok) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         shift_ff     <= SHIFT_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            shift_ff <= csr_wdata[SHIFT_BITS-1:0];
         end
         if (state_ff == S_EMIT && emit_ok) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         idx_ff    <= req_idx;
         chan_ff   <= req_channel;
         sample_ff <= req_sample;
      end
      if (state_ff == S_ACCUM) begin
         sum_ff    <= sum_new;
         peak_ff   <= peak_new;
         trough_ff <= trough_new;
      end
      if (state_ff == S_MEAN) begin
         mean_ff <= mean_in;
      end
      level_ff <= level_in;
      if (state_ff == S_EMIT && emit_ok) begin
         rsp_chan_ff  <= chan_ff;
         rsp_level_ff <= level_ff;
         rsp_mean_ff  <= mean_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TBITS'({rsp_mean_ff, rsp_level_ff, rsp_chan_ff});

   // Checks
   a_div_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV)
      else $error("divider finished outside the divide state");

   a_quot_range: assert property (@(posedge clock) disable iff (reset)
      div_done |-> div_quot < LEVEL_TOP)
      else $error("quotient reached the top of the scale");

   a_span_pos: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> lim_hi > lim_lo)
      else $error("limits collapsed while dividing");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_level_ff <= LEVEL_TOP)
      else $error("level above scale top");

   a_mean_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LIMIT |-> $past(state_ff) == S_MEAN)
      else $error("limit check entered without a fresh mean");

endmodule
